// File: hdl/csc_pkg.sv
// Shared field widths and result codes for the cycle sort block.
`default_nettype none

package csc_pkg;

    localparam int IDX_W    = 10;
    localparam int VAL_W    = 32;
    localparam int CMP_W    = 32;
    localparam int WR_W     = 11;
    localparam int STATUS_W = 2;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic KIND_SORT_DONE = 1'b0;
    localparam logic KIND_READ_DATA = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

endpackage

`default_nettype wire

// File: hdl/cycle_sort_with_counters.sv
// Load, in-place cycle sort with compare and write counters, and indexed read-back.
`default_nettype none

// Loads are taken while the block is idle and give no result, except the load marked
// last, which runs an in-place cycle sort over the stored elements and then gives one
// item with the compare and write counts. All sort work goes through the element
// memory, one read or one write at a time, under a small sequencer: each counted
// compare follows a read of the element, and each element write follows a read of
// the slot it replaces. A read stalls the input until its result, first registered
// from memory, is loaded into the output register, which waits while that register is
// still held. The input stalls while a read or a sort is under way; a finished item
// waits in the output register and a new item is taken while it waits.
module cycle_sort_with_counters #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int VALUE_BITS   = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              req_type,
    input  wire logic signed [csc_pkg::VAL_W-1:0]  element_value,
    input  wire logic                              last_element,
    input  wire logic [csc_pkg::IDX_W-1:0]         read_index,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   result_kind,
    output logic signed [csc_pkg::VAL_W-1:0]       read_value,
    output logic [csc_pkg::CMP_W-1:0]              compare_count,
    output logic [csc_pkg::WR_W-1:0]               write_count,
    output logic [csc_pkg::STATUS_W-1:0]           status
);

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int XW = (AW > csc_pkg::IDX_W) ? AW : csc_pkg::IDX_W;
    localparam int RW = CW + csc_pkg::IDX_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_RD_OUT   = 4'd1;
    localparam logic [3:0] S_OUTER    = 4'd2;
    localparam logic [3:0] S_ITEM     = 4'd3;
    localparam logic [3:0] S_SCAN_RD  = 4'd4;
    localparam logic [3:0] S_SCAN_CMP = 4'd5;
    localparam logic [3:0] S_SKIP_CHK = 4'd6;
    localparam logic [3:0] S_SKIP_CMP = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    logic [VALUE_BITS-1:0] mem [MAX_ELEMENTS];
    logic [VALUE_BITS-1:0] rdata_reg;

    logic [3:0]                     state_reg, state_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic                           overflow_reg, overflow_next;
    logic                           batch_done_reg, batch_done_next;
    logic                           in_range_reg, in_range_next;
    logic [CW-1:0]                  cs_reg, cs_next;
    logic [CW-1:0]                  pos_reg, pos_next;
    logic [CW-1:0]                  j_reg, j_next;
    logic                           first_reg, first_next;
    logic [VALUE_BITS-1:0]          item_reg, item_next;
    logic [csc_pkg::CMP_W-1:0]      cmp_reg, cmp_next;
    logic [csc_pkg::WR_W-1:0]       wr_reg, wr_next;

    logic                           out_valid_reg, out_valid_next;
    logic                           kind_reg, kind_next;
    logic [csc_pkg::VAL_W-1:0]      value_reg, value_next;
    logic [csc_pkg::CMP_W-1:0]      ocmp_reg, ocmp_next;
    logic [csc_pkg::WR_W-1:0]       owr_reg, owr_next;
    logic [csc_pkg::STATUS_W-1:0]   status_reg, status_next;

    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr;
    logic [VALUE_BITS-1:0]          mem_wdata;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;

    logic [XW-1:0]                  idx_wide;
    logic                           idx_ok;
    logic                           lt;
    logic                           eq;
    logic                           out_free;
    logic [csc_pkg::CMP_W-1:0]      cmp_inc;
    logic [csc_pkg::WR_W-1:0]       wr_inc;

    assign idx_wide = XW'(read_index);
    assign idx_ok   = RW'(read_index) < RW'(count_reg);
    assign lt       = $signed(rdata_reg) < $signed(item_reg);
    assign eq       = rdata_reg == item_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign cmp_inc  = (&cmp_reg) ? cmp_reg : cmp_reg + 1'b1;
    assign wr_inc   = (&wr_reg) ? wr_reg : wr_reg + 1'b1;

    always_comb
    begin
        logic [CW-1:0] ec;
        logic          ovf;

        ec              = batch_done_reg ? '0 : count_reg;
        ovf             = batch_done_reg ? 1'b0 : overflow_reg;
        state_next      = state_reg;
        count_next      = count_reg;
        overflow_next   = overflow_reg;
        batch_done_next = batch_done_reg;
        in_range_next   = in_range_reg;
        cs_next         = cs_reg;
        pos_next        = pos_reg;
        j_next          = j_reg;
        first_next      = first_reg;
        item_next       = item_reg;
        cmp_next        = cmp_reg;
        wr_next         = wr_reg;
        out_valid_next  = out_valid_reg && out_stall;
        kind_next       = kind_reg;
        value_next      = value_reg;
        ocmp_next       = ocmp_reg;
        owr_next        = owr_reg;
        status_next     = status_reg;
        mem_we          = 1'b0;
        mem_waddr       = pos_reg[AW-1:0];
        mem_wdata       = item_reg;
        rd_en           = 1'b0;
        rd_addr         = pos_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == csc_pkg::REQ_READ)
                    begin
                        rd_en         = 1'b1;
                        rd_addr       = idx_wide[AW-1:0];
                        in_range_next = idx_ok;
                        state_next    = S_RD_OUT;
                    end
                    else
                    begin
                        if (ec < CW'(MAX_ELEMENTS))
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = ec[AW-1:0];
                            mem_wdata  = VALUE_BITS'($unsigned(element_value));
                            count_next = ec + 1'b1;
                        end
                        else
                        begin
                            count_next = ec;
                            ovf        = 1'b1;
                        end
                        overflow_next   = ovf;
                        batch_done_next = 1'b0;
                        if (last_element)
                        begin
                            batch_done_next = 1'b1;
                            cs_next         = '0;
                            cmp_next        = '0;
                            wr_next         = '0;
                            state_next      = S_OUTER;
                        end
                    end
                end
            end
            S_RD_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = csc_pkg::KIND_READ_DATA;
                    value_next     = in_range_reg ? csc_pkg::VAL_W'(rdata_reg) : '0;
                    ocmp_next      = '0;
                    owr_next       = '0;
                    status_next    = in_range_reg ? csc_pkg::STATUS_OK : csc_pkg::STATUS_RANGE;
                    state_next     = S_IDLE;
                end
            end
            S_OUTER:
            begin
                if (cs_reg + 1'b1 < count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = cs_reg[AW-1:0];
                    state_next = S_ITEM;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_ITEM:
            begin
                item_next  = rdata_reg;
                pos_next   = cs_reg;
                j_next     = cs_reg + 1'b1;
                first_next = 1'b1;
                state_next = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                if (j_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = j_reg[AW-1:0];
                    state_next = S_SCAN_CMP;
                end
                else
                begin
                    state_next = S_SKIP_CHK;
                end
            end
            S_SCAN_CMP:
            begin
                cmp_next = cmp_inc;
                if (lt)
                begin
                    pos_next = pos_reg + 1'b1;
                end
                j_next     = j_reg + 1'b1;
                state_next = S_SCAN_RD;
            end
            S_SKIP_CHK:
            begin
                if ((first_reg && pos_reg == cs_reg) || pos_reg >= count_reg)
                begin
                    cs_next    = cs_reg + 1'b1;
                    state_next = S_OUTER;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = pos_reg[AW-1:0];
                    state_next = S_SKIP_CMP;
                end
            end
            S_SKIP_CMP:
            begin
                if (eq)
                begin
                    pos_next   = pos_reg + 1'b1;
                    cmp_next   = cmp_inc;
                    state_next = S_SKIP_CHK;
                end
                else
                begin
                    mem_we     = 1'b1;
                    item_next  = rdata_reg;
                    wr_next    = wr_inc;
                    first_next = 1'b0;
                    if (pos_reg != cs_reg)
                    begin
                        pos_next   = cs_reg;
                        j_next     = cs_reg + 1'b1;
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        cs_next    = cs_reg + 1'b1;
                        state_next = S_OUTER;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = csc_pkg::KIND_SORT_DONE;
                    value_next     = '0;
                    ocmp_next      = cmp_reg;
                    owr_next       = wr_reg;
                    status_next    = overflow_reg ? csc_pkg::STATUS_OVERFLOW : csc_pkg::STATUS_OK;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
            batch_done_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            overflow_reg   <= overflow_next;
            batch_done_reg <= batch_done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_range_reg <= in_range_next;
        cs_reg       <= cs_next;
        pos_reg      <= pos_next;
        j_reg        <= j_next;
        first_reg    <= first_next;
        item_reg     <= item_next;
        cmp_reg      <= cmp_next;
        wr_reg       <= wr_next;
        kind_reg     <= kind_next;
        value_reg    <= value_next;
        ocmp_reg     <= ocmp_next;
        owr_reg      <= owr_next;
        status_reg   <= status_next;
    end

    assign in_stall      = state_reg != S_IDLE;
    assign out_valid     = out_valid_reg;
    assign result_kind   = kind_reg;
    assign read_value    = $signed(value_reg);
    assign compare_count = ocmp_reg;
    assign write_count   = owr_reg;
    assign status        = status_reg;

endmodule

`default_nettype wire
